/* rtl/scop_pkg.sv */
// Shared types and constants for the scanline occlusion path cost block.
// Used by every module of the block but scop_ram; depends on nothing.
`timescale 1ns / 1ps

package scop_pkg;

    localparam int IDX_W   = 10;
    localparam int WID_W   = 11;
    localparam int POS_W   = 12;
    localparam int OCC_W   = 16;
    localparam int COST_W  = 24;
    localparam int SUM_W   = 29;
    localparam int DEPTH   = 1024;
    localparam int CNT_W   = 11;

    localparam logic [1:0] REG_LEFT_WIDTH  = 2'd0;
    localparam logic [1:0] REG_RIGHT_WIDTH = 2'd1;
    localparam logic [1:0] REG_OCC_COST    = 2'd2;
    localparam logic [1:0] REG_DIRECTION   = 2'd3;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    typedef struct packed {
        logic [WID_W-1:0] lw;
        logic [WID_W-1:0] rw;
        logic [OCC_W-1:0] occ;
        logic             dir;
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0]  l;
        logic [IDX_W-1:0]  r;
        logic [COST_W-1:0] mcost;
        logic              fol;
        logic [WID_W-1:0]  diag;
        logic              inr;
    } item_t;

    typedef struct packed {
        logic [COST_W-1:0] path;
        logic              sat;
    } res_t;

    typedef struct packed {
        logic [COST_W-1:0]       cn;
        logic signed [POS_W-1:0] pn;
        logic [COST_W-1:0]       cp;
        logic signed [POS_W-1:0] pp;
    } track_t;

    typedef struct packed {
        logic [IDX_W-1:0]  l;
        logic [IDX_W-1:0]  r;
        logic [COST_W-1:0] cost;
    } pend_t;

endpackage

/* rtl/scop_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module scop_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/scop_front.sv */
// Input queue of two items that classifies each match on entry.
// Depends on scop_pkg.
`timescale 1ns / 1ps

module scop_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [scop_pkg::IDX_W-1:0]  match_left,
    input  logic [scop_pkg::IDX_W-1:0]  match_right,
    input  logic [scop_pkg::COST_W-1:0] match_cost,
    input  logic                        first_of_line,
    input  scop_pkg::cfg_t              cfg,
    output logic                        item_valid,
    output scop_pkg::item_t             item,
    input  logic                        take
);

    scop_pkg::item_t q_reg [2];
    logic            head_reg, head_next;
    logic            tail_reg, tail_next;
    logic [1:0]      cnt_reg, cnt_next;
    scop_pkg::item_t in_item;
    logic            do_push, do_pop;

    always_comb
    begin
        in_item.l     = match_left;
        in_item.r     = match_right;
        in_item.mcost = match_cost;
        in_item.fol   = first_of_line;
        in_item.diag  = {1'b0, match_left} + {1'b0, match_right};
        in_item.inr   = ({1'b0, match_left} < cfg.lw) && ({1'b0, match_right} < cfg.rw);
    end

    assign full       = (cnt_reg == 2'd2);
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = q_reg[head_reg];
    assign do_push    = push && !full;
    assign do_pop     = take && item_valid;

    always_comb
    begin
        head_next = do_pop ? ~head_reg : head_reg;
        tail_next = do_push ? ~tail_reg : tail_reg;
        cnt_next  = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= 1'b0;
            tail_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[tail_reg] <= in_item;
        end
    end

endmodule

/* rtl/scop_resq.sv */
// Result queue of two items between the back end and the result ports.
// Depends on scop_pkg.
`timescale 1ns / 1ps

module scop_resq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        res_push,
    input  scop_pkg::res_t              res,
    output logic                        res_full,
    output logic                        empty,
    input  logic                        pop,
    output logic [scop_pkg::COST_W-1:0] path_cost,
    output logic                        saturated
);

    scop_pkg::res_t q_reg [2];
    logic           head_reg, head_next;
    logic           tail_reg, tail_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           do_push, do_pop;

    assign res_full  = (cnt_reg == 2'd2);
    assign empty     = (cnt_reg == 2'd0);
    assign path_cost = q_reg[head_reg].path;
    assign saturated = q_reg[head_reg].sat;
    assign do_push   = res_push && !res_full;
    assign do_pop    = pop && !empty;

    always_comb
    begin
        head_next = do_pop ? ~head_reg : head_reg;
        tail_next = do_push ? ~tail_reg : tail_reg;
        cnt_next  = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= 1'b0;
            tail_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[tail_reg] <= res;
        end
    end

endmodule

/* rtl/scop_back.sv */
// Sequencer that reloads and updates the tracks and computes path costs.
// Depends on scop_pkg and scop_ram.
`timescale 1ns / 1ps

module scop_back (
    input  logic            clk,
    input  logic            rst_n,
    input  scop_pkg::cfg_t  cfg,
    input  logic            item_valid,
    input  scop_pkg::item_t item,
    output logic            take,
    input  logic            res_full,
    output logic            res_push,
    output scop_pkg::res_t  res
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SWEEP = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_F_RDP = 4'd3;
    localparam logic [3:0] S_F_RDT = 4'd4;
    localparam logic [3:0] S_F_WR  = 4'd5;
    localparam logic [3:0] S_RD    = 4'd6;
    localparam logic [3:0] S_CALC  = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    localparam int PEN_W = scop_pkg::OCC_W + scop_pkg::POS_W;

    function automatic logic [PEN_W-1:0] pen_f(input logic [scop_pkg::OCC_W-1:0] occ,
                                                input logic signed [scop_pkg::POS_W:0] d);
        logic [scop_pkg::POS_W-1:0] du;
        du = d[scop_pkg::POS_W] ? '0 : d[scop_pkg::POS_W-1:0];
        return {{scop_pkg::POS_W{1'b0}}, occ} * {{scop_pkg::OCC_W{1'b0}}, du};
    endfunction

    function automatic logic [scop_pkg::SUM_W-1:0] rd_f(input scop_pkg::track_t t,
                                                        input logic signed [scop_pkg::POS_W-1:0] x,
                                                        input logic dir,
                                                        input logic [scop_pkg::OCC_W-1:0] occ);
        logic                              use_prev;
        logic [scop_pkg::COST_W-1:0]       c;
        logic signed [scop_pkg::POS_W-1:0] p;
        logic signed [scop_pkg::POS_W:0]   d;
        use_prev = dir ? (x > t.pn) : (x < t.pn);
        c = use_prev ? t.cp : t.cn;
        p = use_prev ? t.pp : t.pn;
        d = dir ? ({p[scop_pkg::POS_W-1], p} - {x[scop_pkg::POS_W-1], x})
                : ({x[scop_pkg::POS_W-1], x} - {p[scop_pkg::POS_W-1], p});
        return {5'b0, c} + {1'b0, pen_f(occ, d)};
    endfunction

    function automatic scop_pkg::track_t push_f(input scop_pkg::track_t t,
                                                input logic signed [scop_pkg::POS_W-1:0] np,
                                                input logic [scop_pkg::COST_W-1:0] inc,
                                                input logic dir,
                                                input logic [scop_pkg::OCC_W-1:0] occ);
        logic signed [scop_pkg::POS_W:0] d;
        logic [scop_pkg::SUM_W-1:0]      c;
        scop_pkg::track_t                o;
        d = dir ? ({t.pn[scop_pkg::POS_W-1], t.pn} - {np[scop_pkg::POS_W-1], np})
                : ({np[scop_pkg::POS_W-1], np} - {t.pn[scop_pkg::POS_W-1], t.pn});
        c = {5'b0, t.cn} + {1'b0, pen_f(occ, d)};
        if ({5'b0, inc} < c)
        begin
            c = {5'b0, inc};
        end
        o.cp = t.cn;
        o.pp = t.pn;
        o.cn = (c > {5'b0, scop_pkg::COST_MAX}) ? scop_pkg::COST_MAX : c[scop_pkg::COST_W-1:0];
        o.pn = np;
        return o;
    endfunction

    function automatic logic [scop_pkg::COST_W-1:0] ramp_f(input logic [scop_pkg::OCC_W-1:0] occ,
                                                           input logic [scop_pkg::WID_W-1:0] i);
        logic [scop_pkg::OCC_W+scop_pkg::WID_W-1:0] p;
        p = {{scop_pkg::WID_W{1'b0}}, occ} * {{scop_pkg::OCC_W{1'b0}}, i};
        return (p > {3'b0, scop_pkg::COST_MAX}) ? scop_pkg::COST_MAX : p[scop_pkg::COST_W-1:0];
    endfunction

    logic [3:0]                   state_reg, state_next;
    scop_pkg::item_t              item_reg, item_next;
    logic [scop_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [scop_pkg::WID_W-1:0]   diag_reg, diag_next;
    logic [scop_pkg::CNT_W-1:0]   idx_reg, idx_next;
    scop_pkg::pend_t              pend_reg, pend_next;
    logic [scop_pkg::SUM_W-1:0]   cl_reg, cl_next;
    logic [scop_pkg::SUM_W-1:0]   cr_reg, cr_next;

    logic                         l_we, r_we, p_we;
    logic [scop_pkg::IDX_W-1:0]   l_waddr, r_waddr, p_waddr;
    logic [scop_pkg::IDX_W-1:0]   l_raddr, r_raddr, p_raddr;
    scop_pkg::track_t             l_wdata, r_wdata;
    scop_pkg::pend_t              p_wdata;
    logic [$bits(scop_pkg::track_t)-1:0] l_rdata, r_rdata;
    logic [$bits(scop_pkg::pend_t)-1:0]  p_rdata;

    scop_pkg::pend_t                   pr, pf;
    logic signed [scop_pkg::POS_W-1:0] nl_rd, nr_rd, nl_wr, nr_wr, xl, xr;
    logic                              nl_ok, nr_ok;
    logic [scop_pkg::WID_W-1:0]        sweep_max, li, ri;
    logic [scop_pkg::SUM_W-1:0]        path;
    logic [scop_pkg::SUM_W:0]          tot;

    scop_ram #(.WIDTH($bits(scop_pkg::track_t)), .DEPTH(scop_pkg::DEPTH)) u_left (
        .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .raddr(l_raddr), .rdata(l_rdata)
    );

    scop_ram #(.WIDTH($bits(scop_pkg::track_t)), .DEPTH(scop_pkg::DEPTH)) u_right (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(r_rdata)
    );

    scop_ram #(.WIDTH($bits(scop_pkg::pend_t)), .DEPTH(scop_pkg::DEPTH)) u_pend (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    always_comb
    begin
        pr    = scop_pkg::pend_t'(p_rdata);
        pf    = pend_reg;
        nl_rd = cfg.dir ? ($signed({2'b0, pr.l}) - 12'sd1) : ($signed({2'b0, pr.l}) + 12'sd1);
        nr_rd = cfg.dir ? ($signed({2'b0, pr.r}) - 12'sd1) : ($signed({2'b0, pr.r}) + 12'sd1);
        nl_wr = cfg.dir ? ($signed({2'b0, pf.l}) - 12'sd1) : ($signed({2'b0, pf.l}) + 12'sd1);
        nr_wr = cfg.dir ? ($signed({2'b0, pf.r}) - 12'sd1) : ($signed({2'b0, pf.r}) + 12'sd1);
        nl_ok = !nl_wr[scop_pkg::POS_W-1] && (nl_wr < $signed({1'b0, cfg.lw}));
        nr_ok = !nr_wr[scop_pkg::POS_W-1] && (nr_wr < $signed({1'b0, cfg.rw}));
        xl    = $signed({2'b0, item_reg.l});
        xr    = $signed({2'b0, item_reg.r});
        sweep_max = (cfg.lw > cfg.rw) ? cfg.lw : cfg.rw;
        li    = cfg.dir ? (cfg.rw - 11'd1 - idx_reg) : idx_reg;
        ri    = cfg.dir ? (cfg.lw - 11'd1 - idx_reg) : idx_reg;
        path  = (cl_reg < cr_reg) ? cl_reg : cr_reg;
        tot   = {1'b0, path} + {6'b0, item_reg.mcost};
    end

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        cnt_next   = cnt_reg;
        diag_next  = diag_reg;
        idx_next   = idx_reg;
        pend_next  = pend_reg;
        cl_next    = cl_reg;
        cr_next    = cr_reg;
        take       = 1'b0;
        res_push   = 1'b0;
        res.path   = '0;
        res.sat    = 1'b0;
        l_we       = 1'b0;
        r_we       = 1'b0;
        p_we       = 1'b0;
        l_waddr    = idx_reg[scop_pkg::IDX_W-1:0];
        r_waddr    = idx_reg[scop_pkg::IDX_W-1:0];
        p_waddr    = cnt_reg[scop_pkg::IDX_W-1:0];
        l_wdata.cn = ramp_f(cfg.occ, li);
        l_wdata.cp = ramp_f(cfg.occ, li);
        l_wdata.pn = cfg.dir ? $signed({1'b0, cfg.lw - 11'd1}) : '0;
        l_wdata.pp = cfg.dir ? $signed({1'b0, cfg.lw - 11'd1}) : '0;
        r_wdata.cn = ramp_f(cfg.occ, ri);
        r_wdata.cp = ramp_f(cfg.occ, ri);
        r_wdata.pn = cfg.dir ? $signed({1'b0, cfg.rw - 11'd1}) : '0;
        r_wdata.pp = cfg.dir ? $signed({1'b0, cfg.rw - 11'd1}) : '0;
        p_wdata.l    = item_reg.l;
        p_wdata.r    = item_reg.r;
        p_wdata.cost = (tot > {6'b0, scop_pkg::COST_MAX}) ? scop_pkg::COST_MAX
                                                          : tot[scop_pkg::COST_W-1:0];
        l_raddr    = item_reg.r;
        r_raddr    = item_reg.l;
        p_raddr    = idx_reg[scop_pkg::IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid && !res_full)
                begin
                    take      = 1'b1;
                    item_next = item;
                    idx_next  = '0;
                    if (item.fol)
                    begin
                        cnt_next   = '0;
                        diag_next  = item.diag;
                        state_next = S_SWEEP;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_SWEEP:
            begin
                l_we     = (idx_reg < cfg.rw);
                r_we     = (idx_reg < cfg.lw);
                idx_next = idx_reg + 11'd1;
                if (idx_reg + 11'd1 >= sweep_max)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                idx_next = '0;
                if (!item_reg.inr)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
                else if (cnt_reg != '0 && item_reg.diag != diag_reg)
                begin
                    state_next = S_F_RDP;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_F_RDP:
            begin
                state_next = S_F_RDT;
            end
            S_F_RDT:
            begin
                pend_next  = pr;
                l_raddr    = nr_rd[scop_pkg::IDX_W-1:0];
                r_raddr    = nl_rd[scop_pkg::IDX_W-1:0];
                state_next = S_F_WR;
            end
            S_F_WR:
            begin
                l_we     = nr_ok;
                l_waddr  = nr_wr[scop_pkg::IDX_W-1:0];
                l_wdata  = push_f(scop_pkg::track_t'(l_rdata), nl_wr, pf.cost, cfg.dir, cfg.occ);
                r_we     = nl_ok;
                r_waddr  = nl_wr[scop_pkg::IDX_W-1:0];
                r_wdata  = push_f(scop_pkg::track_t'(r_rdata), nr_wr, pf.cost, cfg.dir, cfg.occ);
                idx_next = idx_reg + 11'd1;
                if (idx_reg + 11'd1 >= cnt_reg)
                begin
                    cnt_next   = '0;
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_F_RDP;
                end
            end
            S_RD:
            begin
                state_next = S_CALC;
            end
            S_CALC:
            begin
                cl_next    = rd_f(scop_pkg::track_t'(l_rdata), xl, cfg.dir, cfg.occ);
                cr_next    = rd_f(scop_pkg::track_t'(r_rdata), xr, cfg.dir, cfg.occ);
                state_next = S_FIN;
            end
            S_FIN:
            begin
                diag_next = item_reg.diag;
                if (cnt_reg < 11'(scop_pkg::DEPTH))
                begin
                    p_we     = 1'b1;
                    cnt_next = cnt_reg + 11'd1;
                end
                res_push = 1'b1;
                if (path > {5'b0, scop_pkg::COST_MAX})
                begin
                    res.path = scop_pkg::COST_MAX;
                    res.sat  = 1'b1;
                end
                else
                begin
                    res.path = path[scop_pkg::COST_W-1:0];
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            diag_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            diag_reg  <= diag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        idx_reg  <= idx_next;
        pend_reg <= pend_next;
        cl_reg   <= cl_next;
        cr_reg   <= cr_next;
    end

endmodule

/* rtl/scanline_occlusion_path_cost.sv */
// Top level: configuration registers, input queue, sequencer and result queue.
// Depends on scop_pkg, scop_front, scop_back and scop_resq.
//
//   Channel   Handshake              Payload
//   input     push / full            match_left, match_right, match_cost, first_of_line
//   result    empty / pop            path_cost, saturated
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A match passes through the sequencer states idle, check, read, calc and finish,
// or returns from check to idle when an index is out of range. A pending diagonal
// change adds the states read-pending, read-tracks and write per buffered update,
// and a first-of-line item adds a sweep over max(left_width, right_width) entries
// for the ramp reload. The track and update memories each give one read and one
// write per cycle. Reset clears the queues and the sequencer; the memories are
// not cleared. Each side stalls on its own through its queue.
`timescale 1ns / 1ps

module scanline_occlusion_path_cost (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [scop_pkg::IDX_W-1:0]  match_left,
    input  logic [scop_pkg::IDX_W-1:0]  match_right,
    input  logic [scop_pkg::COST_W-1:0] match_cost,
    input  logic                        first_of_line,
    output logic                        empty,
    input  logic                        pop,
    output logic [scop_pkg::COST_W-1:0] path_cost,
    output logic                        saturated,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [scop_pkg::OCC_W-1:0]  cfg_data
);

    logic [scop_pkg::WID_W-1:0] lw_reg, rw_reg;
    logic [scop_pkg::OCC_W-1:0] occ_reg;
    logic                       dir_reg;
    scop_pkg::cfg_t             cfg;
    logic                       item_valid, take, res_full, res_push;
    scop_pkg::item_t            item;
    scop_pkg::res_t             res;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg.lw  = (lw_reg == '0) ? 11'd1 : ((lw_reg > 11'd1024) ? 11'd1024 : lw_reg);
        cfg.rw  = (rw_reg == '0) ? 11'd1 : ((rw_reg > 11'd1024) ? 11'd1024 : rw_reg);
        cfg.occ = occ_reg;
        cfg.dir = dir_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_reg  <= 11'd1024;
            rw_reg  <= 11'd1024;
            occ_reg <= 16'd256;
            dir_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                scop_pkg::REG_LEFT_WIDTH:  lw_reg  <= cfg_data[scop_pkg::WID_W-1:0];
                scop_pkg::REG_RIGHT_WIDTH: rw_reg  <= cfg_data[scop_pkg::WID_W-1:0];
                scop_pkg::REG_OCC_COST:    occ_reg <= cfg_data;
                scop_pkg::REG_DIRECTION:   dir_reg <= cfg_data[0];
                default:                   dir_reg <= dir_reg;
            endcase
        end
    end

    scop_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .match_left(match_left), .match_right(match_right),
        .match_cost(match_cost), .first_of_line(first_of_line),
        .cfg(cfg), .item_valid(item_valid), .item(item), .take(take)
    );

    scop_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .item_valid(item_valid),
        .item(item), .take(take), .res_full(res_full),
        .res_push(res_push), .res(res)
    );

    scop_resq u_resq (
        .clk(clk), .rst_n(rst_n), .res_push(res_push), .res(res),
        .res_full(res_full), .empty(empty), .pop(pop),
        .path_cost(path_cost), .saturated(saturated)
    );

endmodule
